>>> sv/afir_pkg.sv
`default_nettype none
package afir_pkg;

  localparam int TAP_COUNT = 64;
  localparam int ROM_DEPTH = 64;
  localparam int PTR_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int SAMPLE_W = 16;
  localparam int ACC_W = 32;
  localparam int WORD_W = 32;
  localparam int TAP_IDX_W = 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last_tap;
    logic pipe_busy;
    logic out_full;
  } sts_t;

  localparam sample_t TAP_ROM [ROM_DEPTH] = '{
    -16'sd11, 16'sd9, 16'sd46, 16'sd100, 16'sd143, 16'sd136, 16'sd55, -16'sd88,
    -16'sd227, -16'sd273, -16'sd159, 16'sd99, 16'sd384, 16'sd521, 16'sd369, -16'sd68,
    -16'sd600, -16'sd915, -16'sd743, -16'sd44, 16'sd901, 16'sd1567, 16'sd1438, 16'sd331,
    -16'sd1395, -16'sd2872, -16'sd3050, -16'sd1186, 16'sd2723, 16'sd7806, 16'sd12563,
    16'sd15435,
    16'sd15435, 16'sd12563, 16'sd7806, 16'sd2723, -16'sd1186, -16'sd3050, -16'sd2872,
    -16'sd1395,
    16'sd331, 16'sd1438, 16'sd1567, 16'sd901, -16'sd44, -16'sd743, -16'sd915, -16'sd600,
    -16'sd68, 16'sd369, 16'sd521, 16'sd384, 16'sd99, -16'sd159, -16'sd273, -16'sd227,
    -16'sd88, 16'sd55, 16'sd136, 16'sd143, 16'sd100, 16'sd46, 16'sd9, -16'sd11
  };

  // Taps past the end of the table count as zero.
  function automatic sample_t tap_coef(input logic [TAP_IDX_W-1:0] idx);
    sample_t coef;
    if (idx < TAP_IDX_W'(ROM_DEPTH)) begin
      coef = TAP_ROM[idx[5:0]];
    end else begin
      coef = '0;
    end
    return coef;
  endfunction

endpackage
`default_nettype wire

>>> sv/afir_ctrl.sv
`default_nettype none
module afir_ctrl
  import afir_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (sts_i.last_tap) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy && !sts_i.out_full) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
      end
      ST_DRAIN: begin
        cmd_o.finish = !sts_i.pipe_busy && !sts_i.out_full;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // A new word is only taken once the previous result has left the pipeline.
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !sts_i.pipe_busy)
    else $error("word loaded while MAC pipeline busy");

  a_finish_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !$past(cmd_o.load))
    else $error("finish directly after load");

  a_issue_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> !in_ready_o)
    else $error("input ready while taps are being walked");
`endif

endmodule
`default_nettype wire

>>> sv/afir_dp.sv
`default_nettype none
module afir_dp
  import afir_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire  [WORD_W-1:0] in_word_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic [WORD_W-1:0] out_word_o,
  output logic              out_valid_o,
  input  wire               out_ready_i
);

  // Delay line memory; entries not yet written since reset read as zero.
  logic [SAMPLE_W-1:0] mem [TAP_COUNT];
  logic [TAP_COUNT-1:0] valid_q;

  logic [PTR_W-1:0] wp_q, rd_ptr_q;
  logic [PTR_W-1:0] tap_idx_q;

  logic [SAMPLE_W-1:0] rd_data_q;
  logic rd_ok_q;
  sample_t coef_q;
  logic s1_vld_q, s2_vld_q;
  logic signed [ACC_W-1:0] prod_q;
  logic [ACC_W-1:0] acc_q;
  logic [WORD_W-1:0] out_word_q;
  logic out_vld_q;

  logic [SAMPLE_W-1:0] mono;
  sample_t sample;

  assign mono = in_word_i[31:16] + in_word_i[15:0];
  assign sample = rd_ok_q ? sample_t'(rd_data_q) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem[wp_q] <= mono;
    end
    rd_data_q <= mem[rd_ptr_q];
    coef_q    <= tap_coef(TAP_IDX_W'(tap_idx_q));
    prod_q    <= sample * coef_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      wp_q      <= '0;
      rd_ptr_q  <= '0;
      tap_idx_q <= '0;
      rd_ok_q   <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      acc_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      rd_ok_q  <= valid_q[rd_ptr_q];
      s1_vld_q <= cmd_i.issue;
      s2_vld_q <= s1_vld_q;
      if (cmd_i.load) begin
        valid_q[wp_q] <= 1'b1;
        rd_ptr_q      <= wp_q;
        tap_idx_q     <= '0;
        acc_q         <= '0;
      end else begin
        if (cmd_i.issue) begin
          rd_ptr_q  <= (rd_ptr_q == '0) ? PTR_W'(TAP_COUNT - 1) : rd_ptr_q - 1'b1;
          tap_idx_q <= tap_idx_q + 1'b1;
        end
        if (s2_vld_q) begin
          acc_q <= acc_q + prod_q;
        end
      end
      if (cmd_i.finish) begin
        wp_q      <= (wp_q == PTR_W'(TAP_COUNT - 1)) ? '0 : wp_q + 1'b1;
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_word_q <= {acc_q[31:16], acc_q[31:16]};
    end
  end

  assign sts_o.last_tap  = tap_idx_q == PTR_W'(TAP_COUNT - 1);
  assign sts_o.pipe_busy = s1_vld_q || s2_vld_q;
  assign sts_o.out_full  = out_vld_q;
  assign out_word_o  = out_word_q;
  assign out_valid_o = out_vld_q;

`ifndef NO_ASSERTIONS
  a_finish_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !s1_vld_q && !s2_vld_q)
    else $error("result taken before accumulation finished");

  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> $past(s1_vld_q))
    else $error("product stage valid without read stage");

  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_vld_q)
    else $error("result register not loaded");
`endif

endmodule
`default_nettype wire

>>> sv/audio_fir_filter_64tap.sv
// Flow: once an input word is accepted, the single multiply-accumulate
// unit walks the 64 taps one per cycle, drains its pipeline and registers
// the result word onto the output. No new word is taken until the
// previous one is finished, and a result still waiting on the output
// holds the next one.
// Reset: rst_ni (asynchronous, active low) clears the delay line valid bits,
// the write pointer, the controller and the output valid flag.
`default_nettype none
module audio_fir_filter_64tap
  import afir_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire  [WORD_W-1:0] s_axis_tdata,   // [31:0] stereo_word
  output logic              m_axis_tvalid,
  input  wire               m_axis_tready,
  output logic [WORD_W-1:0] m_axis_tdata    // [31:0] speaker_word
);

  cmd_t cmd;
  sts_t sts;

  afir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  afir_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_word_o  (m_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

endmodule
`default_nettype wire
